[rtl/utf16_to_utf8_encoder_defines.svh]
// Assertion macros shared by the UTF-16 to UTF-8 encoder RTL.
`ifndef UTF16_TO_UTF8_ENCODER_DEFINES_SVH
`define UTF16_TO_UTF8_ENCODER_DEFINES_SVH

`ifndef SYNTH

// Checked at every clock edge outside reset.
`define U2U8_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("u2u8 assertion failed");

// Checked at every clock edge, reset included.
`define U2U8_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("u2u8 assertion failed");

`else

`define U2U8_ASSERT(lbl, prop)
`define U2U8_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

[rtl/u2u8_pkg.sv]
// Shared types, constants and byte-encoding functions of the UTF-16 to UTF-8 encoder.
`timescale 1ns / 1ps

package u2u8_pkg;

  // Upper six bits of a high surrogate (0xd800..0xdbff) and a low one (0xdc00..0xdfff).
  localparam logic [5:0] HighSurrTag = 6'h36;
  localparam logic [5:0] LowSurrTag  = 6'h37;

  // Base of the supplementary planes and the replacement character.
  localparam logic [20:0] SuppBase    = 21'h10000;
  localparam logic [20:0] ReplaceChar = 21'h00fffd;

  // Lead-byte markers and the continuation marker.
  localparam logic [7:0] Lead2Mark = 8'hc0;
  localparam logic [7:0] Lead3Mark = 8'he0;
  localparam logic [7:0] Lead4Mark = 8'hf0;
  localparam logic [7:0] ContMark  = 8'h80;

  // One unit of work for the byte sequencer: an optional U+FFFD for a
  // dropped surrogate, then an optional code point.
  typedef struct packed {
    logic        pre_rep;
    logic        has_cp;
    logic [2:0]  cp_len;
    logic [20:0] cp;
    logic        fin;
  } job_t;

  // Number of UTF-8 bytes a code point takes.
  function automatic logic [2:0] cp_len(input logic [20:0] cp);
    logic [2:0] len;
    if (cp < 21'h80) begin
      len = 3'd1;
    end else if (cp < 21'h800) begin
      len = 3'd2;
    end else if (cp < SuppBase) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Byte number idx of the UTF-8 form of a code point of the given length.
  function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [2:0] len,
                                          input logic [1:0] idx);
    logic [7:0] b;
    b = cp[7:0];
    case (len)
      3'd2: begin
        b = (idx == 2'd0) ? (Lead2Mark | {3'b000, cp[10:6]}) : (ContMark | {2'b00, cp[5:0]});
      end
      3'd3: begin
        case (idx)
          2'd0:    b = Lead3Mark | {4'b0000, cp[15:12]};
          2'd1:    b = ContMark | {2'b00, cp[11:6]};
          default: b = ContMark | {2'b00, cp[5:0]};
        endcase
      end
      3'd4: begin
        case (idx)
          2'd0:    b = Lead4Mark | {5'b00000, cp[20:18]};
          2'd1:    b = ContMark | {2'b00, cp[17:12]};
          2'd2:    b = ContMark | {2'b00, cp[11:6]};
          default: b = ContMark | {2'b00, cp[5:0]};
        endcase
      end
      default: b = cp[7:0];
    endcase
    return b;
  endfunction

endpackage

[rtl/u2u8_front.sv]
// Front end: accepts code units, pairs surrogates and issues byte jobs.
`timescale 1ns / 1ps

module u2u8_front import u2u8_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] code_unit_i,
  input  logic        final_unit_i,
  input  logic        push,
  output logic        full,
  input  logic        q_full_i,
  output logic        job_push_o,
  output job_t        job_o
);

  logic       pending_q, pending_d;
  logic [9:0] pend_bits_q, pend_bits_d;
  logic       accept;
  logic       is_high;
  logic       is_low;
  logic [20:0] pair_cp;
  logic [20:0] unit_cp;

  // Input is refused only while the job queue has no room.
  assign full   = q_full_i;
  assign accept = push && !q_full_i;

  // Classify the unit.
  assign is_high = (code_unit_i[15:10] == HighSurrTag);
  assign is_low  = (code_unit_i[15:10] == LowSurrTag);
  assign pair_cp = SuppBase + {1'b0, pend_bits_q, code_unit_i[9:0]};
  assign unit_cp = (is_high || is_low) ? ReplaceChar : {5'b00000, code_unit_i};

  // Build the job for this unit.
  always_comb begin
    job_o.fin = final_unit_i;
    if (pending_q && is_low) begin
      job_o.pre_rep = 1'b0;
      job_o.has_cp  = 1'b1;
      job_o.cp      = pair_cp;
    end else begin
      job_o.pre_rep = pending_q;
      job_o.has_cp  = !(is_high && !final_unit_i);
      job_o.cp      = unit_cp;
    end
    job_o.cp_len = cp_len(job_o.cp);
  end

  // A held high surrogate with nothing before it produces no job.
  assign job_push_o = accept && (job_o.pre_rep || job_o.has_cp);

  // Held surrogate state.
  always_comb begin
    pending_d   = pending_q;
    pend_bits_d = pend_bits_q;
    if (accept) begin
      pending_d   = is_high && !final_unit_i;
      pend_bits_d = (is_high && !final_unit_i) ? code_unit_i[9:0] : 10'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 1'b0;
      pend_bits_q <= 10'd0;
    end else begin
      pending_q   <= pending_d;
      pend_bits_q <= pend_bits_d;
    end
  end

endmodule

[rtl/u2u8_jobq.sv]
// Short job queue between the front end and the byte sequencer.
`timescale 1ns / 1ps
`include "utf16_to_utf8_encoder_defines.svh"

module u2u8_jobq import u2u8_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t wr_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t rd_job_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o   = (count_q == CntW'(Depth));
  assign empty_o  = (count_q == '0);
  assign rd_job_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  `U2U8_ASSERT(a_count_bound, count_q <= CntW'(Depth))
  `U2U8_ASSERT(a_no_pop_empty, empty_o |-> !pop_i)
  `U2U8_ASSERT(a_push_grows, (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))

endmodule

[rtl/u2u8_back.sv]
// Back end: expands jobs into UTF-8 bytes, one beat per cycle while the output register is free or taken.
`timescale 1ns / 1ps
`include "utf16_to_utf8_encoder_defines.svh"

module u2u8_back import u2u8_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  job_t       q_job_i,
  output logic       q_pop_o,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_end_o
);

  job_t       cur_job_q, cur_job_d;
  logic       cur_valid_q, cur_valid_d;
  logic       in_pre_q, in_pre_d;
  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d;
  logic       run_last_q, run_last_d;
  logic       str_end_q, str_end_d;
  logic       advance;
  logic       emit;
  logic       pre_end;
  logic       last_byte;
  logic       load;
  logic [7:0] cur_byte;

  // The output register moves when it is free or being taken.
  assign advance = !out_valid_q || pop;
  assign emit    = advance && cur_valid_q;

  // Current byte and whether it ends the job.
  assign pre_end   = in_pre_q && (idx_q == 2'd2);
  assign last_byte = in_pre_q ? (pre_end && !cur_job_q.has_cp)
                              : ({1'b0, idx_q} == (cur_job_q.cp_len - 3'd1));
  assign cur_byte  = in_pre_q ? enc_byte(ReplaceChar, 3'd3, idx_q)
                              : enc_byte(cur_job_q.cp, cur_job_q.cp_len, idx_q);

  // Fetch the next job as the current one finishes.
  assign load    = !cur_valid_q || (emit && last_byte);
  assign q_pop_o = load && !q_empty_i;

  // Sequencer state.
  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_job_d   = cur_job_q;
    in_pre_d    = in_pre_q;
    idx_d       = idx_q;
    if (load) begin
      cur_valid_d = !q_empty_i;
    end
    if (q_pop_o) begin
      cur_job_d = q_job_i;
      in_pre_d  = q_job_i.pre_rep;
      idx_d     = 2'd0;
    end else if (emit) begin
      if (pre_end) begin
        in_pre_d = 1'b0;
        idx_d    = 2'd0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    run_last_d  = run_last_q;
    str_end_d   = str_end_q;
    if (advance) begin
      out_valid_d = cur_valid_q;
      byte_d      = cur_byte;
      run_last_d  = last_byte;
      str_end_d   = last_byte && cur_job_q.fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      in_pre_q    <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      in_pre_q    <= in_pre_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_job_q  <= cur_job_d;
    byte_q     <= byte_d;
    run_last_q <= run_last_d;
    str_end_q  <= str_end_d;
  end

  assign empty        = !out_valid_q;
  assign out_byte_o   = byte_q;
  assign run_last_o   = run_last_q;
  assign string_end_o = str_end_q;

  `U2U8_ASSERT(a_idx_in_range, (cur_valid_q && !in_pre_q) |-> ({1'b0, idx_q} < cur_job_q.cp_len))
  `U2U8_ASSERT(a_pre_from_job, (cur_valid_q && in_pre_q) |-> cur_job_q.pre_rep)
  `U2U8_ASSERT(a_end_is_last, (out_valid_q && str_end_q) |-> run_last_q)

endmodule

[rtl/utf16_to_utf8_encoder.sv]
// Top level of the UTF-16 to UTF-8 encoder: front end, job queue and byte sequencer.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake       Beat
// input     in         push / full     code_unit_i, final_unit_i
// result    out        empty / pop     out_byte_o, run_last_o, string_end_o
//
// A code unit is taken whenever the job queue has room; it
// yields zero to six bytes, and the sequencer emits one byte per cycle
// while the result register is free or being popped.
// The one-byte result register sets the sustained rate.
// Reset clears the held surrogate, the queue and the valid flags of the sequencer and the output register.
// A stalled result side fills the queue (JobDepth jobs) before full rises.

module utf16_to_utf8_encoder import u2u8_pkg::*; #(
  parameter int JobDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] code_unit_i,
  input  logic        final_unit_i,
  input  logic        push,
  output logic        full,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        string_end_o,
  output logic        empty,
  input  logic        pop
);

  job_t front_job;
  job_t q_job;
  logic job_push;
  logic q_full;
  logic q_empty;
  logic q_pop;

  u2u8_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .code_unit_i  (code_unit_i),
    .final_unit_i (final_unit_i),
    .push         (push),
    .full         (full),
    .q_full_i     (q_full),
    .job_push_o   (job_push),
    .job_o        (front_job)
  );

  u2u8_jobq #(
    .Depth (JobDepth)
  ) u_jobq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (job_push),
    .wr_job_i (front_job),
    .full_o   (q_full),
    .pop_i    (q_pop),
    .empty_o  (q_empty),
    .rd_job_o (q_job)
  );

  u2u8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_job_i      (q_job),
    .q_pop_o      (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

endmodule
